@@ src/svalloc_pkg.sv @@
package svalloc_pkg;

  // Width of the freed-channel mask in a result.
  localparam int unsigned MaskBits = 16;

  // Reset values of the configuration registers.
  localparam logic [4:0] ChannelsReset = 5'd8;
  localparam logic       EnableReset   = 1'b1;

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    CMD_START       = 2'd0,
    CMD_STOP_SOURCE = 2'd1,
    CMD_FINISHED    = 2'd2,
    CMD_STOP_ALL    = 2'd3
  } cmd_e;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_NONE     = 2'd1,
    ST_STOPPED  = 2'd2,
    ST_DISABLED = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_CHANNELS = 1'b0,
    REG_ENABLE   = 1'b1
  } reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_STEAL,
    S_STOP_SRC,
    S_FINISH,
    S_STOP_ALL
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] source_id;
    logic [2:0]  sound_class;
    logic [7:0]  priority_level;
    logic [3:0]  finished_channel;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  granted_channel;
    logic [15:0] freed_mask;
    logic        stolen;
  } result_t;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic [4:0] channels_in_use;
    logic       sound_enabled;
  } cfg_t;

  // Outcome of the shared compare unit for the channel under scan.
  typedef struct packed {
    logic same_voice;
    logic same_source;
    logic can_evict;
  } cmp_t;

endpackage

@@ src/svalloc_regs.sv @@
module svalloc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output svalloc_pkg::cfg_t   cfg_o
);

  logic [4:0]         channels_q;
  logic               enable_q;
  logic               wr_en;
  svalloc_pkg::reg_e  sel;

  assign pready = 1'b1;
  assign sel    = svalloc_pkg::reg_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= svalloc_pkg::ChannelsReset;
      enable_q   <= svalloc_pkg::EnableReset;
    end else if (wr_en) begin
      case (sel)
        svalloc_pkg::REG_CHANNELS: channels_q <= pwdata[4:0];
        svalloc_pkg::REG_ENABLE:   enable_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (sel)
      svalloc_pkg::REG_CHANNELS: prdata = {27'd0, channels_q};
      svalloc_pkg::REG_ENABLE:   prdata = {31'd0, enable_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.channels_in_use = channels_q;
  assign cfg_o.sound_enabled   = enable_q;

endmodule

@@ src/svalloc_mem.sv @@
module svalloc_mem #(
  parameter int unsigned AW = 4,
  parameter int unsigned DW = 27
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/svalloc_cmp.sv @@
module svalloc_cmp #(
  parameter int unsigned SW = 16
) (
  input  logic [SW-1:0]     ent_src_i,
  input  logic [2:0]        ent_cls_i,
  input  logic [7:0]        ent_pri_i,
  input  logic [SW-1:0]     key_src_i,
  input  logic [2:0]        key_cls_i,
  input  logic [7:0]        key_pri_i,
  output svalloc_pkg::cmp_t cmp_o
);

  logic src_eq;

  // Compare the stored voice against the request key.
  assign src_eq           = (ent_src_i == key_src_i);
  assign cmp_o.same_source = src_eq;
  assign cmp_o.same_voice  = src_eq && (ent_cls_i == key_cls_i);
  assign cmp_o.can_evict   = (ent_pri_i >= key_pri_i);

endmodule

@@ src/svalloc_seq.sv @@
module svalloc_seq #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned SW           = 16,
  parameter int unsigned IW           = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  svalloc_pkg::item_t     item_i,
  input  svalloc_pkg::cfg_t      cfg_i,
  input  svalloc_pkg::cmp_t      cmp_i,
  output logic [IW-1:0]          raddr_o,
  output logic                   we_o,
  output logic [IW-1:0]          waddr_o,
  output logic [SW-1:0]          key_src_o,
  output logic [2:0]             key_cls_o,
  output logic [7:0]             key_pri_o,
  output logic                   result_valid_o,
  output svalloc_pkg::result_t   result_o
);

  localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned NW = (CW > 5) ? CW : 5;

  svalloc_pkg::state_e    state_q, state_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [MAX_CHANNELS-1:0] active_q, active_d;
  logic [15:0]            mask_q, mask_d;
  svalloc_pkg::result_t   result_q, result_d;
  logic                   valid_q, valid_d;
  svalloc_pkg::cmd_e      cmd_q;
  logic [SW-1:0]          src_q;
  logic [2:0]             cls_q;
  logic [7:0]             pri_q;
  logic [3:0]             fin_q;
  logic                   latch_en;
  logic [NW-1:0]          cfg_n, n_live;
  logic                   at_end;
  logic                   act_cur;
  logic [IW-1:0]          ix;
  logic [IW-1:0]          fin_ix;

  // Mask bit of a channel; channels past the mask width do not show.
  function automatic logic [15:0] mask_bit(input logic [CW-1:0] c);
    logic [15:0] m;
    m = '0;
    if (32'(c) < svalloc_pkg::MaskBits) begin
      m = 16'd1 << c;
    end
    return m;
  endfunction

  // Live channel count, saturated to the channel array size.
  assign cfg_n  = NW'(cfg_i.channels_in_use);
  assign n_live = (cfg_n > NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS) : cfg_n;
  assign at_end = (NW'(idx_q) >= n_live);
  assign ix     = idx_q[IW-1:0];
  assign fin_ix = IW'(fin_q);
  assign act_cur = (idx_q < CW'(MAX_CHANNELS)) ? active_q[ix] : 1'b0;

  // Next state, scan index and result.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    active_d = active_q;
    mask_d   = mask_q;
    result_d = result_q;
    valid_d  = 1'b0;
    latch_en = 1'b0;
    we_o     = 1'b0;
    case (state_q)
      svalloc_pkg::S_IDLE: begin
        if (start_i) begin
          latch_en = 1'b1;
          idx_d    = '0;
          mask_d   = '0;
          if (!cfg_i.sound_enabled) begin
            result_d.status          = svalloc_pkg::ST_DISABLED;
            result_d.granted_channel = '0;
            result_d.freed_mask      = '0;
            result_d.stolen          = 1'b0;
            valid_d                  = 1'b1;
          end else begin
            case (item_i.command)
              svalloc_pkg::CMD_START:       state_d = svalloc_pkg::S_PASS1;
              svalloc_pkg::CMD_STOP_SOURCE: state_d = svalloc_pkg::S_STOP_SRC;
              svalloc_pkg::CMD_FINISHED:    state_d = svalloc_pkg::S_FINISH;
              svalloc_pkg::CMD_STOP_ALL:    state_d = svalloc_pkg::S_STOP_ALL;
              default:                      state_d = svalloc_pkg::S_IDLE;
            endcase
          end
        end
      end

      // Free the first active channel holding the same voice.
      svalloc_pkg::S_PASS1: begin
        if (at_end) begin
          state_d = svalloc_pkg::S_PASS2;
          idx_d   = '0;
        end else if (act_cur && cmp_i.same_voice) begin
          active_d[ix] = 1'b0;
          mask_d       = mask_q | mask_bit(idx_q);
          state_d      = svalloc_pkg::S_PASS2;
          idx_d        = '0;
        end else begin
          idx_d = CW'(idx_q + 1'b1);
        end
      end

      // Look for a free slot, replacing a matching voice of a nonzero source met on the way.
      svalloc_pkg::S_PASS2: begin
        if (at_end) begin
          state_d = svalloc_pkg::S_STEAL;
          idx_d   = '0;
        end else if (!act_cur || ((src_q != '0) && cmp_i.same_voice)) begin
          if (act_cur) begin
            mask_d = mask_q | mask_bit(idx_q);
          end
          active_d[ix]             = 1'b1;
          we_o                     = 1'b1;
          result_d.status          = svalloc_pkg::ST_GRANTED;
          result_d.granted_channel = 4'(idx_q);
          result_d.freed_mask      = mask_d;
          result_d.stolen          = 1'b0;
          valid_d                  = 1'b1;
          state_d                  = svalloc_pkg::S_IDLE;
        end else begin
          idx_d = CW'(idx_q + 1'b1);
        end
      end

      // All channels busy: evict the first one whose priority level is equal to or above the request's.
      svalloc_pkg::S_STEAL: begin
        if (at_end) begin
          result_d.status          = svalloc_pkg::ST_NONE;
          result_d.granted_channel = '0;
          result_d.freed_mask      = mask_q;
          result_d.stolen          = 1'b0;
          valid_d                  = 1'b1;
          state_d                  = svalloc_pkg::S_IDLE;
        end else if (cmp_i.can_evict) begin
          mask_d                   = mask_q | mask_bit(idx_q);
          active_d[ix]             = 1'b1;
          we_o                     = 1'b1;
          result_d.status          = svalloc_pkg::ST_GRANTED;
          result_d.granted_channel = 4'(idx_q);
          result_d.freed_mask      = mask_d;
          result_d.stolen          = 1'b1;
          valid_d                  = 1'b1;
          state_d                  = svalloc_pkg::S_IDLE;
        end else begin
          idx_d = CW'(idx_q + 1'b1);
        end
      end

      // Stop the first active channel of the source.
      svalloc_pkg::S_STOP_SRC: begin
        if (at_end || (act_cur && cmp_i.same_source)) begin
          if (!at_end) begin
            active_d[ix] = 1'b0;
            mask_d       = mask_q | mask_bit(idx_q);
          end
          result_d.status          = svalloc_pkg::ST_STOPPED;
          result_d.granted_channel = '0;
          result_d.freed_mask      = mask_d;
          result_d.stolen          = 1'b0;
          valid_d                  = 1'b1;
          state_d                  = svalloc_pkg::S_IDLE;
        end else begin
          idx_d = CW'(idx_q + 1'b1);
        end
      end

      // Free one finished channel if it is live and playing.
      svalloc_pkg::S_FINISH: begin
        if ((NW'(fin_q) < n_live) && active_q[fin_ix]) begin
          active_d[fin_ix] = 1'b0;
          mask_d           = mask_q | mask_bit(CW'(fin_q));
        end
        result_d.status          = svalloc_pkg::ST_STOPPED;
        result_d.granted_channel = '0;
        result_d.freed_mask      = mask_d;
        result_d.stolen          = 1'b0;
        valid_d                  = 1'b1;
        state_d                  = svalloc_pkg::S_IDLE;
      end

      // Stop every live channel at once.
      svalloc_pkg::S_STOP_ALL: begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          if ((NW'(c) < n_live) && active_q[c]) begin
            active_d[c] = 1'b0;
            mask_d      = mask_d | mask_bit(CW'(c));
          end
        end
        result_d.status          = svalloc_pkg::ST_STOPPED;
        result_d.granted_channel = '0;
        result_d.freed_mask      = mask_d;
        result_d.stolen          = 1'b0;
        valid_d                  = 1'b1;
        state_d                  = svalloc_pkg::S_IDLE;
      end

      default: begin
        state_d = svalloc_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= svalloc_pkg::S_IDLE;
      idx_q    <= '0;
      active_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  // Request key, scan mask and result payload.
  always_ff @(posedge clk_i) begin
    if (latch_en) begin
      cmd_q <= item_i.command;
      src_q <= SW'(item_i.source_id);
      cls_q <= item_i.sound_class;
      pri_q <= item_i.priority_level;
      fin_q <= item_i.finished_channel;
    end
    mask_q   <= mask_d;
    result_q <= result_d;
  end

  assign busy_o         = (state_q != svalloc_pkg::S_IDLE);
  assign raddr_o        = idx_d[IW-1:0];
  assign waddr_o        = ix;
  assign key_src_o      = src_q;
  assign key_cls_o      = cls_q;
  assign key_pri_o      = pri_q;
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  // A grant leaves the granted channel marked active.
  a_grant_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (result_q.status == svalloc_pkg::ST_GRANTED)) |-> act_cur)
    else $error("granted channel is not active");

  // Eviction is only reported together with a grant.
  a_stolen_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && result_q.stolen) |-> (result_q.status == svalloc_pkg::ST_GRANTED))
    else $error("stolen flag without grant");

  // Single-channel stops free at most one channel.
  a_stop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ((cmd_q == svalloc_pkg::CMD_STOP_SOURCE) ||
                 (cmd_q == svalloc_pkg::CMD_FINISHED)))
    |-> $onehot0(result_q.freed_mask))
    else $error("single stop freed several channels");

  // Every completed command produces a result transaction.
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_q)
    else $error("command finished without a result");

endmodule

@@ src/sound_voice_allocator_top.sv @@
// A start scans the voice memory one channel per cycle, in up to three passes over the N
// live channels: same voice, free slot, steal. Stop source scans once; channel finished
// and stop all need no scan. When the block is disabled, the strobe rises at the
// accepting edge itself. No new command is accepted while one is in progress (busy);
// the block is idle again while the strobe is high. The receiver cannot stall the
// strobe. Reset clears all active flags and sets 8 channels, sound enabled.
module sound_voice_allocator_top #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned SOURCE_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  svalloc_pkg::item_t    item_i,
  output logic                  result_valid_o,
  output svalloc_pkg::result_t  result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned SW = (SOURCE_BITS < 16) ? SOURCE_BITS : 16;
  localparam int unsigned IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DW = SW + 3 + 8;

  svalloc_pkg::cfg_t cfg;
  svalloc_pkg::cmp_t cmp;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic              we;
  logic [SW-1:0]     key_src;
  logic [2:0]        key_cls;
  logic [7:0]        key_pri;
  logic [DW-1:0]     rdata;

  svalloc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Per-channel source, class and priority.
  svalloc_mem #(
    .AW (IW),
    .DW (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({key_src, key_cls, key_pri}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared compare unit for the channel under scan.
  svalloc_cmp #(
    .SW (SW)
  ) u_cmp (
    .ent_src_i (rdata[DW-1:11]),
    .ent_cls_i (rdata[10:8]),
    .ent_pri_i (rdata[7:0]),
    .key_src_i (key_src),
    .key_cls_i (key_cls),
    .key_pri_i (key_pri),
    .cmp_o     (cmp)
  );

  svalloc_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SW           (SW),
    .IW           (IW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (item_i),
    .cfg_i          (cfg),
    .cmp_i          (cmp),
    .raddr_o        (raddr),
    .we_o           (we),
    .waddr_o        (waddr),
    .key_src_o      (key_src),
    .key_cls_o      (key_cls),
    .key_pri_o      (key_pri),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
